// File: hdl/windowed_fft_log_spectrum_defines.svh
// Assertion macros used by the spectrum analyser top level.
`ifndef WINDOWED_FFT_LOG_SPECTRUM_DEFINES_SVH
`define WINDOWED_FFT_LOG_SPECTRUM_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while rst_n is low.
`define WFLS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, sampled on clk, off while rst_n is low.
`define WFLS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define WFLS_ASSERT_IMP(lbl, ante, cons, msg)
`define WFLS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// File: hdl/wfls_pkg.sv
// Types, constants and constant tables of the windowed log spectrum block.
package wfls_pkg;

    localparam int FRAME_SIZE = 64;
    localparam int HANN_DEN   = FRAME_SIZE - 1;
    localparam int ADDR_W     = $clog2(FRAME_SIZE);
    localparam int K_W        = $clog2(FRAME_SIZE / 2 + 1);
    localparam int FIRST_BIN  = 2;
    localparam int LAST_BIN_K = FRAME_SIZE / 2;

    localparam int SAMPLE_W   = 32;
    localparam int Q15_W      = 16;
    localparam int WIN_W      = 16;
    localparam int TW_W       = 32;
    localparam int PROD_W     = Q15_W + TW_W;
    localparam int ACC_W      = PROD_W + ADDR_W;
    localparam int RE_W       = ACC_W - 29;
    localparam int SQ_W       = 2 * RE_W;
    localparam int P_W        = SQ_W + 1;
    localparam int LZ_W       = $clog2(P_W);
    localparam int E_W        = $clog2(P_W);
    localparam int LOGY_W     = 31;
    localparam int FRAC_W     = 16;
    localparam int STEP_W     = $clog2(FRAC_W);
    localparam int LOG_W      = E_W + FRAC_W;
    localparam int LN2_W      = 30;
    localparam int GAIN_W     = 16;
    localparam int AMP_W      = 16;
    localparam int BIN_W      = 7;
    localparam int FREQ_W     = 17;
    localparam int RATE_W     = 18;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;
    localparam int GAIN_SHIFT = 9;

    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(44100);
    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(256);
    localparam logic [LN2_W-1:0]  LN2_Q30    = LN2_W'(744261118);
    localparam logic [LOG_W-1:0]  LOG_THR    = LOG_W'(15 << 17);
    localparam logic [AMP_W-1:0]  AMP_MAX    = '1;

    localparam longint unsigned Q30_ONE     = 64'd1 << 30;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLE_WIDTH_MODE = 2'd0,
        CFG_SAMPLE_RATE_HZ    = 2'd1,
        CFG_LOG_GAIN          = 2'd2
    } wfls_cfg_idx_t;

    typedef enum logic [3:0] {
        ST_FILL,
        ST_MAC,
        ST_ROUND,
        ST_SQUARE,
        ST_SUM,
        ST_NORM,
        ST_LOG_SQ,
        ST_LOG_ADJ,
        ST_LN,
        ST_GAIN,
        ST_EMIT
    } wfls_state_t;

    typedef struct packed {
        logic signed [63:0] c;
        logic signed [63:0] s;
    } wfls_cs_t;

    typedef logic signed [TW_W-1:0] wfls_tw_table_t [FRAME_SIZE];
    typedef logic [WIN_W-1:0]       wfls_win_table_t [FRAME_SIZE];

    // cos and sin of a first-octant angle in Q30 radians, truncated series
    function automatic wfls_cs_t octant_cs(longint unsigned x);
        longint unsigned x2;
        longint unsigned vc;
        longint unsigned vs;
        wfls_cs_t r;
        x2 = (x * x) >> 30;
        vc = Q30_ONE;
        vs = Q30_ONE;
        vc = Q30_ONE - ((x2 * vc) >> 30) / 90;
        vs = Q30_ONE - ((x2 * vs) >> 30) / 110;
        vc = Q30_ONE - ((x2 * vc) >> 30) / 56;
        vs = Q30_ONE - ((x2 * vs) >> 30) / 72;
        vc = Q30_ONE - ((x2 * vc) >> 30) / 30;
        vs = Q30_ONE - ((x2 * vs) >> 30) / 42;
        vc = Q30_ONE - ((x2 * vc) >> 30) / 12;
        vs = Q30_ONE - ((x2 * vs) >> 30) / 20;
        vc = Q30_ONE - ((x2 * vc) >> 30) / 2;
        vs = Q30_ONE - ((x2 * vs) >> 30) / 6;
        r.c = $signed(vc);
        r.s = $signed((x * vs) >> 30);
        return r;
    endfunction

    // cos and sin of a turn fraction t (t / 2^32 of a full turn), Q30
    function automatic wfls_cs_t frac_cs(longint unsigned t);
        longint unsigned q;
        longint unsigned u;
        wfls_cs_t o;
        wfls_cs_t tmp;
        wfls_cs_t r;
        q = (t >> 30) & 64'd3;
        u = t & (Q30_ONE - 64'd1);
        if (u <= (Q30_ONE >> 1))
        begin
            o = octant_cs((u * HALF_PI_Q30) >> 30);
        end
        else
        begin
            tmp = octant_cs(((Q30_ONE - u) * HALF_PI_Q30) >> 30);
            o.c = tmp.s;
            o.s = tmp.c;
        end
        case (q)
            64'd0:
            begin
                r.c = o.c;
                r.s = o.s;
            end
            64'd1:
            begin
                r.c = -o.s;
                r.s = o.c;
            end
            64'd2:
            begin
                r.c = -o.c;
                r.s = -o.s;
            end
            default:
            begin
                r.c = o.s;
                r.s = -o.c;
            end
        endcase
        return r;
    endfunction

    function automatic wfls_cs_t twiddle_cs(int i);
        longint unsigned t;
        t = (longint'(i % FRAME_SIZE) << 32) / FRAME_SIZE;
        return frac_cs(t);
    endfunction

    function automatic wfls_tw_table_t build_tw_cos();
        wfls_tw_table_t tab;
        wfls_cs_t cs;
        for (int i = 0; i < FRAME_SIZE; i++)
        begin
            cs = twiddle_cs(i);
            tab[i] = cs.c[TW_W-1:0];
        end
        return tab;
    endfunction

    function automatic wfls_tw_table_t build_tw_sin();
        wfls_tw_table_t tab;
        wfls_cs_t cs;
        for (int i = 0; i < FRAME_SIZE; i++)
        begin
            cs = twiddle_cs(i);
            tab[i] = cs.s[TW_W-1:0];
        end
        return tab;
    endfunction

    // Hann coefficient, Q0.16, saturated to the top code
    function automatic wfls_win_table_t build_hann();
        wfls_win_table_t tab;
        wfls_cs_t cs;
        longint unsigned t;
        longint unsigned w;
        for (int i = 0; i < FRAME_SIZE; i++)
        begin
            t  = (longint'(i % HANN_DEN) << 32) / HANN_DEN;
            cs = frac_cs(t);
            w  = (longint'(Q30_ONE) - cs.c + (64'd1 << 14)) >> 15;
            tab[i] = (w > 64'd65535) ? '1 : w[WIN_W-1:0];
        end
        return tab;
    endfunction

    localparam wfls_tw_table_t  TW_COS    = build_tw_cos();
    localparam wfls_tw_table_t  TW_SIN    = build_tw_sin();
    localparam wfls_win_table_t HANN_WIN  = build_hann();

endpackage

// File: hdl/wfls_stream_if.sv
// Valid/ready stream interfaces for the sample input and the bin results.
interface wfls_sample_if;
    import wfls_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] pcm_sample;

    modport source (output valid, output pcm_sample, input ready);
    modport sink   (input valid, input pcm_sample, output ready);
endinterface

interface wfls_bin_if;
    import wfls_pkg::*;
    logic              valid;
    logic              ready;
    logic [BIN_W-1:0]  bin_index;
    logic [FREQ_W-1:0] bin_frequency_hz;
    logic [AMP_W-1:0]  amplitude;
    logic              last_bin;

    modport source (output valid, output bin_index, output bin_frequency_hz,
                    output amplitude, output last_bin, input ready);
    modport sink   (input valid, input bin_index, input bin_frequency_hz,
                    input amplitude, input last_bin, output ready);
endinterface

// File: hdl/windowed_fft_log_spectrum.sv
// Top level of the Hann-windowed log magnitude spectrum analyser.
//
// Channels: "sample" takes one signed PCM word per transfer; in 16-bit mode
// the low half is used, in 32-bit mode the high half. Each word is windowed
// on arrival and written to the frame RAM. "bin" delivers one result per
// transfer for bins 2..N/2 of every completed frame (N = 64), with last_bin
// high on bin N/2. Configuration is a plain write port (cfg_we, cfg_index,
// cfg_data); write it only while the block is idle.
// Throughput: while a frame fills, one sample per cycle is taken. Once the
// frame is complete, sample.ready drops while the analysis runs: each bin
// needs a multiply-accumulate pass with one frame RAM read per cycle, then
// rounding, squaring, normalisation, a log2 by repeated squaring and the
// conversion to a scaled natural log before its result is handed over.
// Reset: control state clears, the registers take their defaults, the frame
// starts empty. No clearing pass: the frame RAM is always filled first.
// Receiver stall: the result register holds its transfer; the analysis of
// the next bin runs on and waits at the hand-over until the register frees.
`include "windowed_fft_log_spectrum_defines.svh"

module windowed_fft_log_spectrum (
    input  logic                              clk,
    input  logic                              rst_n,
    wfls_sample_if.sink                       sample,
    wfls_bin_if.source                        bin,
    input  logic                              cfg_we,
    input  logic [wfls_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [wfls_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import wfls_pkg::*;

    // configuration registers
    logic              mode_reg;
    logic [RATE_W-1:0] rate_reg;
    logic [GAIN_W-1:0] gain_reg;

    // sequencer
    wfls_state_t state_reg;
    wfls_state_t state_next;

    logic [ADDR_W-1:0] fill_cnt_reg;
    logic [K_W-1:0]    k_reg;
    logic [ADDR_W:0]   iss_cnt_reg;
    logic [ADDR_W-1:0] m_reg;
    logic [ADDR_W-1:0] m1_reg;
    logic              v1_reg;
    logic              v2_reg;

    // datapath
    logic signed [PROD_W-1:0] prod_re_reg;
    logic signed [PROD_W-1:0] prod_im_reg;
    logic signed [ACC_W-1:0]  acc_re_reg;
    logic signed [ACC_W-1:0]  acc_im_reg;
    logic signed [RE_W-1:0]   re_reg;
    logic signed [RE_W-1:0]   im_reg;
    logic signed [SQ_W-1:0]   sq_re_reg;
    logic signed [SQ_W-1:0]   sq_im_reg;
    logic [P_W-1:0]           z_reg;
    logic [LZ_W-1:0]          lz_reg;
    logic [LOGY_W-1:0]        y_reg;
    logic [2*LOGY_W-1:0]      ysq_reg;
    logic [STEP_W-1:0]        step_reg;
    logic [FRAC_W-1:0]        frac_reg;
    logic [LOG_W-1:0]         a_reg;
    logic [AMP_W-1:0]         amp_reg;

    // result register
    logic              out_valid_reg;
    logic [BIN_W-1:0]  out_bin_reg;
    logic [FREQ_W-1:0] out_freq_reg;
    logic [AMP_W-1:0]  out_amp_reg;
    logic              out_last_reg;

    // combinational
    logic                        sample_xfer;
    logic                        in_ready;
    logic                        mac_issue;
    logic                        load_out;
    logic                        out_free;
    logic                        iss_done;
    logic                        last_k;
    logic [Q15_W-1:0]            q15;
    logic [WIN_W-1:0]            win;
    logic signed [Q15_W+WIN_W:0] win_prod;
    logic [Q15_W-1:0]            x_win;
    logic [Q15_W-1:0]            ram_rdata;
    logic [ADDR_W:0]             m_sum;
    logic signed [ACC_W:0]       rnd_re;
    logic signed [ACC_W:0]       rnd_im;
    logic [P_W-1:0]              power;
    logic [LOGY_W:0]             y_sq_top;
    logic [E_W-1:0]              log_int;
    logic [LOG_W-1:0]            log2_val;
    logic [LOG_W+LN2_W-1:0]      ln_prod;
    logic [GAIN_W+LOG_W-1:0]     gain_prod;
    logic [ADDR_W+FREQ_W-1:0]    freq_prod;

    assign sample_xfer = sample.valid && in_ready;
    assign out_free    = !out_valid_reg || bin.ready;
    assign iss_done    = (iss_cnt_reg == (ADDR_W + 1)'(FRAME_SIZE));
    assign last_k      = (k_reg == K_W'(LAST_BIN_K));

    // ---------------------------------------------------------------
    // Configuration: ignore writes beyond the register list
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            rate_reg <= RATE_RESET;
            gain_reg <= GAIN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SAMPLE_WIDTH_MODE: mode_reg <= cfg_data[0];
                CFG_SAMPLE_RATE_HZ:    rate_reg <= cfg_data[RATE_W-1:0];
                CFG_LOG_GAIN:          gain_reg <= cfg_data[GAIN_W-1:0];
                default:               ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Input path: pick the Q1.15 half, apply the window, floor by 2^16
    // ---------------------------------------------------------------
    assign q15      = mode_reg ? sample.pcm_sample[SAMPLE_W-1 -: Q15_W]
                               : sample.pcm_sample[Q15_W-1:0];
    assign win      = HANN_WIN[fill_cnt_reg];
    assign win_prod = $signed(q15) * $signed({1'b0, win});
    assign x_win    = win_prod[Q15_W+WIN_W-1:WIN_W];

    // Writes happen only while filling and reads only during the
    // accumulate pass, so the two ports never touch one entry together.
    wfls_ram #(
        .WIDTH (Q15_W),
        .DEPTH (FRAME_SIZE)
    ) u_frame_ram (
        .clk   (clk),
        .we    (sample_xfer),
        .waddr (fill_cnt_reg),
        .wdata (x_win),
        .re    (mac_issue),
        .raddr (iss_cnt_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // ---------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_FILL:
            begin
                if (sample_xfer && fill_cnt_reg == ADDR_W'(FRAME_SIZE - 1))
                begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                if (iss_done && !v1_reg && !v2_reg)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:  state_next = ST_SQUARE;
            ST_SQUARE: state_next = ST_SUM;
            ST_SUM:
            begin
                state_next = (power == '0) ? ST_EMIT : ST_NORM;
            end
            ST_NORM:
            begin
                if (z_reg[P_W-1])
                begin
                    state_next = ST_LOG_SQ;
                end
            end
            ST_LOG_SQ: state_next = ST_LOG_ADJ;
            ST_LOG_ADJ:
            begin
                state_next = (step_reg == '0) ? ST_LN : ST_LOG_SQ;
            end
            ST_LN:
            begin
                state_next = (log2_val <= LOG_THR) ? ST_EMIT : ST_GAIN;
            end
            ST_GAIN:   state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = last_k ? ST_FILL : ST_MAC;
                end
            end
            default:   state_next = ST_FILL;
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer: outputs
    // ---------------------------------------------------------------
    always_comb
    begin
        in_ready  = 1'b0;
        mac_issue = 1'b0;
        load_out  = 1'b0;
        case (state_reg)
            ST_FILL: in_ready  = 1'b1;
            ST_MAC:  mac_issue = !iss_done;
            ST_EMIT: load_out  = out_free;
            default: ;
        endcase
    end

    assign sample.ready = in_ready;

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            fill_cnt_reg  <= '0;
            k_reg         <= K_W'(FIRST_BIN);
            iss_cnt_reg   <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            v1_reg    <= mac_issue;
            v2_reg    <= v1_reg;

            if (sample_xfer)
            begin
                fill_cnt_reg <= (fill_cnt_reg == ADDR_W'(FRAME_SIZE - 1)) ? '0
                                : fill_cnt_reg + 1'b1;
            end

            // restart the read sweep for every bin
            if (state_reg != ST_MAC)
            begin
                iss_cnt_reg <= '0;
            end
            else if (mac_issue)
            begin
                iss_cnt_reg <= iss_cnt_reg + 1'b1;
            end

            if (load_out)
            begin
                k_reg <= last_k ? K_W'(FIRST_BIN) : k_reg + 1'b1;
            end

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (bin.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Accumulate pass: twiddle index m = k*n mod N kept by adding k
    // ---------------------------------------------------------------
    assign m_sum = {1'b0, m_reg} + (ADDR_W + 1)'(k_reg);

    always_ff @(posedge clk)
    begin
        if (state_reg != ST_MAC)
        begin
            m_reg <= '0;
        end
        else if (mac_issue)
        begin
            m_reg <= (m_sum >= (ADDR_W + 1)'(FRAME_SIZE))
                     ? ADDR_W'(m_sum - (ADDR_W + 1)'(FRAME_SIZE))
                     : m_sum[ADDR_W-1:0];
        end
        m1_reg      <= m_reg;
        prod_re_reg <= $signed(ram_rdata) * TW_COS[m1_reg];
        prod_im_reg <= $signed(ram_rdata) * TW_SIN[m1_reg];

        if (state_reg != ST_MAC)
        begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        else if (v2_reg)
        begin
            acc_re_reg <= acc_re_reg + ACC_W'(prod_re_reg);
            acc_im_reg <= acc_im_reg - ACC_W'(prod_im_reg);
        end
    end

    // ---------------------------------------------------------------
    // Magnitude, log2 and scaling
    // ---------------------------------------------------------------
    assign rnd_re   = {acc_re_reg[ACC_W-1], acc_re_reg} + (ACC_W + 1)'(1 << 29);
    assign rnd_im   = {acc_im_reg[ACC_W-1], acc_im_reg} + (ACC_W + 1)'(1 << 29);
    assign power    = P_W'($unsigned(sq_re_reg)) + P_W'($unsigned(sq_im_reg));
    assign y_sq_top = ysq_reg[LOGY_W+30:30];
    assign log_int  = E_W'(P_W - 1) - E_W'(lz_reg);
    assign log2_val = {log_int, frac_reg};
    assign ln_prod  = (LOG_W + LN2_W)'(log2_val - LOG_THR) * (LOG_W + LN2_W)'(LN2_Q30);
    assign gain_prod = (GAIN_W + LOG_W)'(gain_reg) * (GAIN_W + LOG_W)'(a_reg);
    assign freq_prod = (ADDR_W + FREQ_W)'(k_reg) * (ADDR_W + FREQ_W)'(rate_reg);

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_ROUND:
            begin
                re_reg <= rnd_re[ACC_W:30];
                im_reg <= rnd_im[ACC_W:30];
            end
            ST_SQUARE:
            begin
                sq_re_reg <= re_reg * re_reg;
                sq_im_reg <= im_reg * im_reg;
            end
            ST_SUM:
            begin
                z_reg   <= power;
                lz_reg  <= '0;
                amp_reg <= '0;
            end
            ST_NORM:
            begin
                // bring the leading one to the top, a byte at a time where
                // the top byte is clear, else one bit at a time
                if (z_reg[P_W-1])
                begin
                    y_reg    <= z_reg[P_W-1 -: LOGY_W];
                    step_reg <= STEP_W'(FRAC_W - 1);
                    frac_reg <= '0;
                end
                else if (z_reg[P_W-1 -: 8] == '0)
                begin
                    z_reg  <= z_reg << 8;
                    lz_reg <= lz_reg + LZ_W'(8);
                end
                else
                begin
                    z_reg  <= z_reg << 1;
                    lz_reg <= lz_reg + 1'b1;
                end
            end
            ST_LOG_SQ:
            begin
                ysq_reg <= (2 * LOGY_W)'(y_reg) * (2 * LOGY_W)'(y_reg);
            end
            ST_LOG_ADJ:
            begin
                // square in [1,4): halve and take a fraction bit when >= 2
                if (y_sq_top[LOGY_W])
                begin
                    y_reg              <= y_sq_top[LOGY_W:1];
                    frac_reg[step_reg] <= 1'b1;
                end
                else
                begin
                    y_reg <= y_sq_top[LOGY_W-1:0];
                end
                step_reg <= step_reg - 1'b1;
            end
            ST_LN:
            begin
                a_reg <= ln_prod[LOG_W+LN2_W-1 -: LOG_W];
            end
            ST_GAIN:
            begin
                amp_reg <= (gain_prod[GAIN_W+LOG_W-1:GAIN_SHIFT+AMP_W] != '0) ? AMP_MAX
                           : gain_prod[GAIN_SHIFT +: AMP_W];
            end
            default: ;
        endcase

        if (load_out)
        begin
            out_bin_reg  <= BIN_W'(k_reg);
            out_freq_reg <= freq_prod[ADDR_W +: FREQ_W];
            out_amp_reg  <= amp_reg;
            out_last_reg <= last_k;
        end
    end

    assign bin.valid            = out_valid_reg;
    assign bin.bin_index        = out_bin_reg;
    assign bin.bin_frequency_hz = out_freq_reg;
    assign bin.amplitude        = out_amp_reg;
    assign bin.last_bin         = out_last_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `WFLS_ASSERT_IMP(a_mac_drained, v2_reg, state_reg == ST_MAC,
                     "accumulate pipeline active outside the accumulate pass")
    `WFLS_ASSERT_IMP(a_log_normalised, state_reg == ST_LOG_SQ, y_reg[LOGY_W-1],
                     "log mantissa lost its leading one")
    `WFLS_ASSERT_NXT(a_last_restarts, load_out && last_k,
                     state_reg == ST_FILL && fill_cnt_reg == '0,
                     "frame did not restart after its last bin")
    `WFLS_ASSERT_IMP(a_out_from_emit, $rose(out_valid_reg), $past(state_reg == ST_EMIT),
                     "result register loaded outside the hand-over")
endmodule

// File: hdl/wfls_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wfls_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule
